@@ rtl/core/ledks_pkg.sv @@
package ledks_pkg;

  localparam int FRAME_BITS = 18;
  localparam int FRAME_CNT_W = $clog2(FRAME_BITS);

  localparam logic [5:0] FILL_ONES = 6'b111111;

  localparam logic [3:0] SEL_DIGIT0 = 4'h7;
  localparam logic [3:0] SEL_DIGIT1 = 4'hb;
  localparam logic [3:0] SEL_DIGIT2 = 4'hd;
  localparam logic [3:0] SEL_DIGIT3 = 4'he;
  localparam logic [3:0] SEL_ALL    = 4'hf;
  localparam logic [7:0] SEG_ALL    = 8'hff;

  localparam logic [7:0] REP_FIRST  = 8'h10;
  localparam logic [7:0] REP_LAST   = 8'haf;
  localparam logic [7:0] REP_RELOAD = 8'h90;

  localparam logic [2:0] REG_DIGIT0 = 3'd0;
  localparam logic [2:0] REG_DIGIT1 = 3'd1;
  localparam logic [2:0] REG_DIGIT2 = 3'd2;
  localparam logic [2:0] REG_DIGIT3 = 3'd3;
  localparam logic [2:0] REG_LOCK   = 3'd4;
  localparam logic [2:0] REG_MAIL   = 3'd5;
  localparam logic [2:0] REG_WIFI   = 3'd6;

  localparam logic [2:0] CODE_NONE = 3'd0;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } scan_state_t;

  typedef struct packed {
    logic [3:0] sel;
    logic [7:0] seg;
  } frame_t;

  typedef struct packed {
    logic load;
    logic take;
  } ser_cmd_t;

  typedef struct packed {
    logic busy;
    logic full;
  } ser_stat_t;

  function automatic logic [2:0] button_code_of(input logic [2:0] line);
    logic [2:0] code;
    code = (line < 3'd6) ? line + 3'd1 : CODE_NONE;
    return code;
  endfunction

endpackage

@@ rtl/core/ledks_ser.sv @@
module ledks_ser
  import ledks_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ser_cmd_t  cmd,
  input  frame_t    frame_in,
  output ser_stat_t stat,
  output frame_t    frame_out
);

  logic [FRAME_BITS-1:0]  shift_r;
  logic [FRAME_BITS-1:0]  cap_r;
  logic [FRAME_CNT_W-1:0] cnt_r;
  logic                   busy_r;
  logic                   full_r;

  // pin order: select msb first, six fixed ones, segments msb first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      full_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.load) begin
      busy_r <= 1'b1;
      full_r <= 1'b0;
      cnt_r  <= FRAME_CNT_W'(FRAME_BITS - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        full_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else if (cmd.take) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shift_r <= {frame_in.sel, FILL_ONES, frame_in.seg};
    end else if (busy_r) begin
      shift_r <= {shift_r[FRAME_BITS-2:0], 1'b0};
      cap_r   <= {cap_r[FRAME_BITS-2:0], shift_r[FRAME_BITS-1]};
    end
  end

  assign stat.busy     = busy_r;
  assign stat.full     = full_r;
  assign frame_out.sel = cap_r[FRAME_BITS-1 -: 4];
  assign frame_out.seg = cap_r[7:0];

endmodule

@@ rtl/core/led_digit_and_key_scan_controller.sv @@
// a tick's first frame passes through the 18-bit frame serializer, then the output register
// each further probe frame is serialized once the previous frame has been unloaded
// a new tick is taken only in idle, after the last frame of the tick has been unloaded;
// a digit tick is one frame, a key tick up to 1 + KEY_LINES frames, and output stalls hold the scan
// reset: rst_n synchronous active low clears scan state, registers and channels
module led_digit_and_key_scan_controller
  import ledks_pkg::*;
#(
  parameter int DIGIT_COUNT = 4,
  parameter int KEY_LINES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // key_level, key_probe_levels
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // select_nibble, segment_byte, key_index, button_code
  output logic        out_tuser,  // key_event
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  scan_state_t state_r, state_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic        held_r, held_nxt;
  logic [7:0]  rep_r, rep_nxt;
  logic [7:0]  probe_r, probe_nxt;
  logic [2:0]  line_r, line_nxt;
  logic        m_ev_r, m_ev_nxt;
  logic [2:0]  m_idx_r, m_idx_nxt;
  logic [2:0]  m_code_r, m_code_nxt;
  logic        m_last_r, m_last_nxt;

  logic        out_valid_r, out_valid_nxt;
  frame_t      out_frame_r, out_frame_nxt;
  logic        out_ev_r, out_ev_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic [2:0]  out_code_r, out_code_nxt;
  logic        out_last_r, out_last_nxt;

  logic [7:0]  dig_r [4];
  logic        lock_r, mail_r, wifi_r;

  ser_cmd_t    ser_cmd;
  ser_stat_t   ser_stat;
  frame_t      ser_in, ser_out;

  logic        in_fire, out_fire, unload;
  logic        key_level;
  logic [7:0]  key_probes;
  logic [1:0]  pos;
  frame_t      digit_frame;
  logic [7:0]  rep_inc;
  logic        hit;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign unload     = ser_stat.full && (!out_valid_r || out_fire);
  assign key_level  = in_tdata[0];
  assign key_probes = in_tdata[8:1];
  assign pos        = slot_r[1:0];
  assign rep_inc    = rep_r + 8'd1;
  assign hit        = probe_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_r[0] <= '0;
      dig_r[1] <= '0;
      dig_r[2] <= '0;
      dig_r[3] <= '0;
      lock_r   <= 1'b0;
      mail_r   <= 1'b0;
      wifi_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIGIT0: dig_r[0] <= cfg_data;
        REG_DIGIT1: dig_r[1] <= cfg_data;
        REG_DIGIT2: dig_r[2] <= cfg_data;
        REG_DIGIT3: dig_r[3] <= cfg_data;
        REG_LOCK:   lock_r   <= cfg_data[0];
        REG_MAIL:   mail_r   <= cfg_data[0];
        REG_WIFI:   wifi_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    digit_frame.seg = dig_r[pos];
    unique case (pos)
      2'd0: begin
        digit_frame.sel    = SEL_DIGIT0;
        digit_frame.seg[7] = lock_r;
      end
      2'd1: digit_frame.sel = SEL_DIGIT1;
      2'd2: begin
        digit_frame.sel    = SEL_DIGIT2;
        digit_frame.seg[7] = mail_r;
      end
      default: begin
        digit_frame.sel    = SEL_DIGIT3;
        digit_frame.seg[7] = wifi_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    held_nxt      = held_r;
    rep_nxt       = rep_r;
    probe_nxt     = probe_r;
    line_nxt      = line_r;
    m_ev_nxt      = m_ev_r;
    m_idx_nxt     = m_idx_r;
    m_code_nxt    = m_code_r;
    m_last_nxt    = m_last_r;
    out_valid_nxt = out_valid_r;
    out_frame_nxt = out_frame_r;
    out_ev_nxt    = out_ev_r;
    out_idx_nxt   = out_idx_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    ser_cmd       = '0;
    ser_in        = digit_frame;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      state_nxt    = ST_RUN;
      ser_cmd.load = 1'b1;
      m_ev_nxt     = 1'b0;
      m_idx_nxt    = '0;
      m_code_nxt   = CODE_NONE;
      probe_nxt    = key_probes;
      line_nxt     = '0;
      if (slot_r < 3'(DIGIT_COUNT)) begin
        m_last_nxt = 1'b1;
        slot_nxt   = slot_r + 3'd1;
      end else begin
        ser_in.sel = SEL_ALL;
        ser_in.seg = SEG_ALL;
        m_last_nxt = !(key_level && !held_r);
        slot_nxt   = '0;
        priority if (key_level && held_r) begin
          priority if (rep_inc == REP_FIRST) begin
            rep_nxt = REP_RELOAD;
          end else if (rep_inc == REP_LAST) begin
            rep_nxt  = REP_RELOAD;
            held_nxt = 1'b0;
          end else begin
            rep_nxt = rep_inc;
          end
        end else if (!key_level && held_r) begin
          held_nxt = 1'b0;
          rep_nxt  = '0;
        end else begin
        end
      end
    end

    if (unload) begin
      ser_cmd.take  = 1'b1;
      out_valid_nxt = 1'b1;
      out_frame_nxt = ser_out;
      out_ev_nxt    = m_ev_r;
      out_idx_nxt   = m_idx_r;
      out_code_nxt  = m_code_r;
      out_last_nxt  = m_last_r;
      if (m_last_r) begin
        state_nxt = ST_IDLE;
      end else begin
        // next probe frame, one key line per frame
        ser_cmd.load = 1'b1;
        ser_in.sel   = SEL_ALL;
        ser_in.seg   = 8'd1 << line_r;
        m_ev_nxt     = hit;
        m_idx_nxt    = hit ? line_r : 3'd0;
        m_code_nxt   = hit ? button_code_of(line_r) : CODE_NONE;
        m_last_nxt   = hit || (line_r == 3'(KEY_LINES - 1));
        if (hit) begin
          held_nxt = 1'b1;
        end
        probe_nxt = {1'b0, probe_r[7:1]};
        line_nxt  = line_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      held_r      <= 1'b0;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      held_r      <= held_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r     <= probe_nxt;
    line_r      <= line_nxt;
    m_ev_r      <= m_ev_nxt;
    m_idx_r     <= m_idx_nxt;
    m_code_r    <= m_code_nxt;
    m_last_r    <= m_last_nxt;
    out_frame_r <= out_frame_nxt;
    out_ev_r    <= out_ev_nxt;
    out_idx_r   <= out_idx_nxt;
    out_code_r  <= out_code_nxt;
    out_last_r  <= out_last_nxt;
  end

  ledks_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ser_cmd),
    .frame_in  (ser_in),
    .stat      (ser_stat),
    .frame_out (ser_out)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_code_r, out_idx_r, out_frame_r.seg, out_frame_r.sel};
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

endmodule

@@ bench/led_digit_and_key_scan_controller_test.sv @@
`timescale 1ns / 100ps

module led_digit_and_key_scan_controller_test
  import ledks_pkg::*;
();

  localparam int DIGITS = 4;
  localparam int LINES = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_TICKS = 100;

  typedef struct packed {
    logic [3:0] sel;
    logic [7:0] seg;
    logic key_hit;
    logic [2:0] line;
    logic [2:0] code;
    logic last_beat;
  } scan_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // display and key scan state as predicted
  logic [7:0] digit_segs [4] = '{default: 8'h00};
  logic lock_on = 1'b0;
  logic mail_on = 1'b0;
  logic wifi_on = 1'b0;
  logic [2:0] slot_now = 3'd0;
  logic held = 1'b0;
  logic [7:0] rep_cnt = 8'h00;

  scan_frame_t frames_due [$];
  int mismatches = 0;
  int burst_left = 0;
  int ticks_sent = 0;
  int idle_cycles = 0;
  int stall_cnt = 0;
  int stall_mode = 0;

  led_digit_and_key_scan_controller #(
    .DIGIT_COUNT(DIGITS),
    .KEY_LINES(LINES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 300 == 0) begin
      stall_mode <= $urandom_range(0, 3);
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom);
      2: out_tready <= (stall_cnt % 37) >= 12;
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t timeout, %0d frames still due", $time, frames_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    scan_frame_t f;
    if (rst_n && out_tvalid && out_tready) begin
      if (frames_due.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual tdata %h tuser %b tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        f = frames_due.pop_front();
        check_field("select", 8'(f.sel), 8'(out_tdata[3:0]));
        check_field("segments", f.seg, out_tdata[11:4]);
        check_field("key index", 8'(f.line), 8'(out_tdata[14:12]));
        check_field("key code", 8'(f.code), 8'(out_tdata[17:15]));
        check_field("pad", 8'h00, 8'(out_tdata[23:18]));
        check_field("key event", 8'(f.key_hit), 8'(out_tuser));
        check_field("last", 8'(f.last_beat), 8'(out_tlast));
      end
    end
  end

  function automatic void add_frame(input logic [3:0] sel, input logic [7:0] seg,
                                    input logic hit, input logic [2:0] line,
                                    input logic [2:0] code);
    scan_frame_t f;
    f = '{sel: sel, seg: seg, key_hit: hit, line: line, code: code, last_beat: 1'b0};
    frames_due.push_back(f);
  endfunction

  function automatic void predict_tick(input logic lvl, input logic [7:0] probes);
    logic [7:0] seg;
    logic found;
    scan_frame_t f;
    if (slot_now < DIGITS) begin
      seg = digit_segs[slot_now[1:0]];
      case (slot_now[1:0])
        2'd0: add_frame(SEL_DIGIT0, {lock_on, seg[6:0]}, 1'b0, 3'd0, CODE_NONE);
        2'd1: add_frame(SEL_DIGIT1, seg, 1'b0, 3'd0, CODE_NONE);
        2'd2: add_frame(SEL_DIGIT2, {mail_on, seg[6:0]}, 1'b0, 3'd0, CODE_NONE);
        default: add_frame(SEL_DIGIT3, {wifi_on, seg[6:0]}, 1'b0, 3'd0, CODE_NONE);
      endcase
      slot_now = slot_now + 3'd1;
    end else begin
      add_frame(SEL_ALL, SEG_ALL, 1'b0, 3'd0, CODE_NONE);
      if (lvl && !held) begin
        found = 1'b0;
        for (int i = 0; i < LINES && !found; i++) begin
          if (probes[i]) begin
            add_frame(SEL_ALL, 8'(1 << i), 1'b1, 3'(i), (i < 6) ? 3'(i + 1) : CODE_NONE);
            held = 1'b1;
            found = 1'b1;
          end else begin
            add_frame(SEL_ALL, 8'(1 << i), 1'b0, 3'd0, CODE_NONE);
          end
        end
      end else if (lvl && held) begin
        rep_cnt = rep_cnt + 8'd1;
        if (rep_cnt == REP_FIRST) begin
          rep_cnt = REP_RELOAD;
        end else if (rep_cnt == REP_LAST) begin
          rep_cnt = REP_RELOAD;
          held = 1'b0;
        end
      end else if (!lvl && held) begin
        held = 1'b0;
        rep_cnt = 8'h00;
      end
      slot_now = 3'd0;
    end
    f = frames_due.pop_back();
    f.last_beat = 1'b1;
    frames_due.push_back(f);
  endfunction

  task automatic send_tick(input logic lvl, input logic [7:0] probes);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, probes, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    ticks_sent++;
    predict_tick(lvl, probes);
  endtask

  // fill the digit slots with random levels, then hit the key slot
  task automatic key_scan(input logic lvl, input logic [7:0] probes);
    while (slot_now < DIGITS) send_tick(1'($urandom), 8'($urandom));
    send_tick(lvl, probes);
  endtask

  task automatic wait_frames_out();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (frames_due.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DIGIT0: digit_segs[0] = val;
      REG_DIGIT1: digit_segs[1] = val;
      REG_DIGIT2: digit_segs[2] = val;
      REG_DIGIT3: digit_segs[3] = val;
      REG_LOCK: lock_on = val[0];
      REG_MAIL: mail_on = val[0];
      REG_WIFI: wifi_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_display(input logic [7:0] d0, input logic [7:0] d1, input logic [7:0] d2,
                             input logic [7:0] d3, input logic lock, input logic mail,
                             input logic wifi);
    write_reg(REG_DIGIT0, d0);
    write_reg(REG_DIGIT1, d1);
    write_reg(REG_DIGIT2, d2);
    write_reg(REG_DIGIT3, d3);
    write_reg(REG_LOCK, {7'b0, lock});
    write_reg(REG_MAIL, {7'b0, mail});
    write_reg(REG_WIFI, {7'b0, wifi});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_power_up_scan();
    repeat (2) key_scan(1'b0, 8'h00);
    wait_frames_out();
  endtask

  task automatic test_digit_patterns();
    set_display(8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 1'b0);
    key_scan(1'b0, 8'hff);
    wait_frames_out();
    set_display(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1);
    key_scan(1'b0, 8'h00);
    wait_frames_out();
    set_display(8'h55, 8'haa, 8'h7f, 8'h80, 1'b1, 1'b0, 1'b1);
    key_scan(1'b0, 8'h00);
    wait_frames_out();
  endtask

  task automatic test_key_lines();
    for (int line = 0; line < LINES; line++) begin
      key_scan(1'b1, (line % 2 == 0) ? (8'hff << line) : 8'(1 << line));
      key_scan(1'b0, 8'h00);
    end
    // no line answers the probes
    key_scan(1'b1, 8'h00);
    key_scan(1'b1, 8'hff);
    key_scan(1'b0, 8'hff);
    key_scan(1'b0, 8'h00);
    wait_frames_out();
  endtask

  task automatic test_auto_repeat();
    key_scan(1'b1, 8'h10);
    // count up to the first reload, then on until held clears
    repeat (47) key_scan(1'b1, 8'($urandom));
    key_scan(1'b1, 8'h02);
    key_scan(1'b1, 8'h80);
    key_scan(1'b0, 8'h00);
    wait_frames_out();
  endtask

  task automatic test_random_scan();
    int stop_at;
    int hold_left;
    logic lvl;
    logic [7:0] probes;
    hold_left = 0;
    stop_at = ticks_sent + RANDOM_TICKS;
    for (int phase = 0; ticks_sent < stop_at; phase++) begin
      case (phase)
        0: set_display(8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 1'b1, 1'b0);
        1: set_display(8'h00, 8'hff, 8'h00, 8'hff, 1'b1, 1'b0, 1'b1);
        default: set_display(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             1'($urandom), 1'($urandom), 1'($urandom));
      endcase
      while (ticks_sent < stop_at && ticks_sent < stop_at - RANDOM_TICKS + 40 * (phase + 1)) begin
        case ($urandom_range(0, 2))
          0: probes = 8'(1 << $urandom_range(0, LINES - 1));
          1: probes = 8'($urandom);
          default: probes = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        endcase
        if (hold_left > 0) begin
          lvl = 1'b1;
          hold_left--;
        end else if ($urandom_range(0, 9) < 6) begin
          lvl = 1'b1;
          hold_left = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 12);
        end else begin
          lvl = 1'($urandom);
        end
        key_scan(lvl, probes);
      end
      wait_frames_out();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_power_up_scan();
    test_digit_patterns();
    test_key_lines();
    test_auto_repeat();
    test_random_scan();
    wait_frames_out();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
